// ===== hw/rtl/fcou_pkg.sv =====
// Types, constants and fixed-point helpers for the fly camera orientation update block.
package fcou_pkg;

  localparam int VEC_FRAC_BITS_DEF = 14;

  // Product and operand widths of the shared multiplier
  localparam int PW = 66;
  localparam int MW = 33;

  // CORDIC datapath and angle widths
  localparam int CW    = 34;
  localparam int ANG_W = 28;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] CMD_MOVE   = 2'd0;
  localparam logic [1:0] CMD_TURN   = 2'd1;
  localparam logic [1:0] CMD_RELOAD = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_SPEED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_SPEED  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_YAW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_PITCH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Z     = 3'd6;

  localparam logic DIV_MODE_DIV  = 1'b0;
  localparam logic DIV_MODE_SQRT = 1'b1;

  // Angles in degrees, Q16.16
  localparam logic signed [ANG_W-1:0] DEG_89  = 28'sd5832704;
  localparam logic signed [ANG_W-1:0] DEG_90  = 28'sd5898240;
  localparam logic signed [ANG_W-1:0] DEG_180 = 28'sd11796480;
  localparam logic [31:0]             DEG_360 = 32'd23592960;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032875;

  typedef struct packed {
    logic [1:0]         command;
    logic [3:0]         key_mask;
    logic [15:0]        delta_time;
    logic signed [15:0] mouse_dx;
    logic signed [15:0] mouse_dy;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] front_x;
    logic signed [15:0] front_y;
    logic signed [15:0] front_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic        mode;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
    logic [31:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic              start;
    logic signed [24:0] ang;
  } cor_req_t;

  typedef struct packed {
    logic                done;
    logic signed [MW-1:0] sin_v;
    logic signed [MW-1:0] cos_v;
  } cor_rsp_t;

  // Arctangent of 2^-i in degrees, Q16.16
  function automatic logic [21:0] arc_angle(input logic [3:0] i);
    logic [21:0] a;
    unique case (i)
      4'd0:  a = 22'd2949120;
      4'd1:  a = 22'd1740967;
      4'd2:  a = 22'd919879;
      4'd3:  a = 22'd466945;
      4'd4:  a = 22'd234379;
      4'd5:  a = 22'd117304;
      4'd6:  a = 22'd58666;
      4'd7:  a = 22'd29335;
      4'd8:  a = 22'd14668;
      4'd9:  a = 22'd7334;
      4'd10: a = 22'd3667;
      4'd11: a = 22'd1833;
      4'd12: a = 22'd917;
      4'd13: a = 22'd458;
      4'd14: a = 22'd229;
      4'd15: a = 22'd115;
    endcase
    return a;
  endfunction

  // Shift right with rounding to nearest, halves away from zero
  function automatic logic signed [PW-1:0] rnd_sh(input logic signed [PW-1:0] v, input int s);
    logic [PW-1:0] mag;
    logic [PW-1:0] half;
    half = PW'(1) << (s - 1);
    mag  = v[PW-1] ? PW'(-v) : PW'(v);
    mag  = (mag + half) >> s;
    return v[PW-1] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
    logic signed [31:0] r;
    if (!v[PW-1] && (|v[PW-2:31]))      r = 32'sh7fff_ffff;
    else if (v[PW-1] && !(&v[PW-2:31])) r = 32'sh8000_0000;
    else                                r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [PW-1:0] v);
    logic signed [15:0] r;
    if (!v[PW-1] && (|v[PW-2:15]))      r = 16'sh7fff;
    else if (v[PW-1] && !(&v[PW-2:15])) r = 16'sh8000;
    else                                r = v[15:0];
    return r;
  endfunction

endpackage

// ===== hw/rtl/fly_camera_orientation_update.sv =====
// Fly camera: position stepping, yaw/pitch update and orientation vector refresh.
// Move steps the position once per pressed key; an unused command goes straight to the result;
// turn and reload are bound by the shared divide/square-root unit (12 operations per
// refresh) and two 16-step CORDIC passes.
// Throughput: one item at a time; a new item is taken as soon as the result is parked.
// Reset (synchronous, rst_n low): registers, pose and orientation return to start values.
module fly_camera_orientation_update import fcou_pkg::*; #(
  parameter int VEC_FRAC_BITS = VEC_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Q30 -> vector fraction bits
  localparam int VSH = 30 - VEC_FRAC_BITS;
  // One in vector format; saturates once it no longer fits 16 bits
  localparam logic signed [15:0] UNIT =
    (VEC_FRAC_BITS >= 15) ? 16'sd32767 : 16'(1 << VEC_FRAC_BITS);

  // Sequencer states
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_MV_VEL  = 5'd1;
  localparam logic [4:0] S_MV_VLAT = 5'd2;
  localparam logic [4:0] S_MV_MUL  = 5'd3;
  localparam logic [4:0] S_MV_ADD  = 5'd4;
  localparam logic [4:0] S_TN_YMUL = 5'd5;
  localparam logic [4:0] S_TN_YDIV = 5'd6;
  localparam logic [4:0] S_TN_YWT  = 5'd7;
  localparam logic [4:0] S_TN_PMUL = 5'd8;
  localparam logic [4:0] S_TN_PADD = 5'd9;
  localparam logic [4:0] S_RL      = 5'd10;
  localparam logic [4:0] S_RF_CY   = 5'd11;
  localparam logic [4:0] S_RF_CYW  = 5'd12;
  localparam logic [4:0] S_RF_CP   = 5'd13;
  localparam logic [4:0] S_RF_CPW  = 5'd14;
  localparam logic [4:0] S_RF_F0   = 5'd15;
  localparam logic [4:0] S_RF_F2   = 5'd16;
  localparam logic [4:0] S_RF_F2L  = 5'd17;
  localparam logic [4:0] S_NZ_SQ   = 5'd18;
  localparam logic [4:0] S_NZ_ACC  = 5'd19;
  localparam logic [4:0] S_NZ_SQRT = 5'd20;
  localparam logic [4:0] S_NZ_SQW  = 5'd21;
  localparam logic [4:0] S_NZ_DIV  = 5'd22;
  localparam logic [4:0] S_NZ_DIVW = 5'd23;
  localparam logic [4:0] S_NZ_END  = 5'd24;
  localparam logic [4:0] S_UP_0    = 5'd25;
  localparam logic [4:0] S_UP_1    = 5'd26;
  localparam logic [4:0] S_UP_2    = 5'd27;
  localparam logic [4:0] S_UP_3    = 5'd28;
  localparam logic [4:0] S_UP_4    = 5'd29;
  localparam logic [4:0] S_VEC_OUT = 5'd30;
  localparam logic [4:0] S_DONE    = 5'd31;

  // Which vector the normalize pass is working on
  localparam logic [1:0] VS_FRONT = 2'd0;
  localparam logic [1:0] VS_RIGHT = 2'd1;
  localparam logic [1:0] VS_UP    = 2'd2;

  // Configuration registers
  logic [23:0]        move_speed_r;
  logic [23:0]        turn_speed_r;
  logic signed [24:0] start_yaw_r;
  logic signed [23:0] start_pitch_r;
  logic signed [31:0] start_x_r;
  logic signed [31:0] start_y_r;
  logic signed [31:0] start_z_r;

  // Architectural state
  logic signed [31:0] cam_r   [3];
  logic signed [24:0] yaw_r;
  logic signed [23:0] pitch_r;
  logic signed [15:0] front_r [3];
  logic signed [15:0] right_r [3];
  logic signed [15:0] up_r    [3];

  // Sequencer and datapath
  logic [4:0]           state_r;
  in_item_t             it_r;
  logic [1:0]           k_r;
  logic [1:0]           c_r;
  logic [1:0]           vsel_r;
  logic [24:0]          vel_r;
  logic                 ysgn_r;
  logic signed [MW-1:0] sy_r, cy_r, sp_r, cp_r;
  logic signed [MW-1:0] w_r [3];
  logic signed [MW-1:0] f_r [3];
  logic signed [MW-1:0] r_r [3];
  logic [63:0]          sum_r;
  logic [31:0]          len_r;
  logic signed [PW-1:0] acc_r;
  logic signed [PW-1:0] prod_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  // Shared multiplier operands
  logic signed [MW-1:0] mul_a, mul_b;

  div_req_t div_req;
  div_rsp_t div_rsp;
  cor_req_t cor_req;
  cor_rsp_t cor_rsp;

  logic                 accept;
  logic signed [15:0]   dir;
  logic signed [PW-1:0] step_d;
  logic signed [PW-1:0] yaw_sum;
  logic [PW-1:0]        yaw_abs;
  logic signed [PW-1:0] pitch_sum;
  logic [31:0]          yaw_mod;
  logic signed [32:0]   yaw_new;
  logic [MW-1:0]        wmag;
  logic [40:0]          vel_sum;

  fcou_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  fcou_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cor_req),
    .rsp   (cor_rsp)
  );

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    // Direction for a key step: W and S use front, A and D use right
    dir     = k_r[1] ? right_r[c_r] : front_r[c_r];
    step_d  = rnd_sh(prod_r, VEC_FRAC_BITS);
    // S and A step backward
    if (k_r[0] ^ k_r[1]) step_d = -step_d;
    vel_sum = prod_r[40:0] + 41'd32768;

    // Yaw wraps into [-180, 180): floored remainder of (yaw + 180) by 360
    yaw_sum = PW'(yaw_r) + prod_r + PW'(DEG_180);
    yaw_abs = yaw_sum[PW-1] ? PW'(-yaw_sum) : PW'(yaw_sum);
    yaw_mod = (ysgn_r && (div_rsp.rem != '0)) ? (DEG_360 - div_rsp.rem) : div_rsp.rem;
    yaw_new = $signed({1'b0, yaw_mod}) - 33'(DEG_180);

    pitch_sum = PW'(pitch_r) + prod_r;
    wmag      = w_r[c_r][MW-1] ? MW'(-w_r[c_r]) : MW'(w_r[c_r]);
  end

  // Operand select for the one multiplier; product is registered every cycle
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MV_VEL: begin
        mul_a = $signed(MW'(move_speed_r));
        mul_b = $signed(MW'(it_r.delta_time));
      end
      S_MV_MUL: begin
        mul_a = $signed(MW'(vel_r));
        mul_b = MW'(dir);
      end
      S_TN_YMUL: begin
        mul_a = MW'(it_r.mouse_dx);
        mul_b = $signed(MW'(turn_speed_r));
      end
      S_TN_PMUL: begin
        mul_a = MW'(it_r.mouse_dy);
        mul_b = $signed(MW'(turn_speed_r));
      end
      S_RF_F0: begin
        mul_a = cy_r;
        mul_b = cp_r;
      end
      S_RF_F2: begin
        mul_a = sy_r;
        mul_b = cp_r;
      end
      S_NZ_SQ: begin
        mul_a = w_r[c_r];
        mul_b = w_r[c_r];
      end
      // up = right x front, with right_y == 0
      S_UP_0: begin
        mul_a = r_r[2];
        mul_b = f_r[1];
      end
      S_UP_1: begin
        mul_a = r_r[2];
        mul_b = f_r[0];
      end
      S_UP_2: begin
        mul_a = r_r[0];
        mul_b = f_r[2];
      end
      S_UP_3: begin
        mul_a = r_r[0];
        mul_b = f_r[1];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Requests to the shared divide/root unit and the CORDIC
  always_comb begin
    div_req       = '0;
    cor_req       = '0;
    div_req.mode  = DIV_MODE_DIV;
    unique case (state_r)
      S_TN_YDIV: begin
        div_req.start = 1'b1;
        div_req.num   = yaw_abs[63:0];
        div_req.den   = DEG_360;
      end
      S_NZ_SQRT: begin
        div_req.start = 1'b1;
        div_req.mode  = DIV_MODE_SQRT;
        div_req.num   = sum_r;
      end
      S_NZ_DIV: begin
        // component * 2^30 / length, rounded to nearest
        div_req.start = (len_r != '0);
        div_req.num   = (64'(wmag) << 30) + 64'(len_r[31:1]);
        div_req.den   = len_r;
      end
      S_RF_CY: begin
        cor_req.start = 1'b1;
        cor_req.ang   = yaw_r;
      end
      S_RF_CP: begin
        cor_req.start = 1'b1;
        cor_req.ang   = 25'(pitch_r);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_speed_r  <= 24'd655360;
      turn_speed_r  <= 24'd655360;
      start_yaw_r   <= '0;
      start_pitch_r <= '0;
      start_x_r     <= '0;
      start_y_r     <= 32'sd131072;
      start_z_r     <= 32'sd131072;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MOVE_SPEED:  move_speed_r  <= cfg_data[23:0];
        CFG_TURN_SPEED:  turn_speed_r  <= cfg_data[23:0];
        CFG_START_YAW:   start_yaw_r   <= cfg_data[24:0];
        CFG_START_PITCH: start_pitch_r <= cfg_data[23:0];
        CFG_START_X:     start_x_r     <= cfg_data;
        CFG_START_Y:     start_y_r     <= cfg_data;
        CFG_START_Z:     start_z_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PW'(mul_a) * PW'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cam_r[0]    <= '0;
      cam_r[1]    <= 32'sd131072;
      cam_r[2]    <= 32'sd131072;
      yaw_r       <= '0;
      pitch_r     <= '0;
      front_r[0]  <= UNIT;
      front_r[1]  <= '0;
      front_r[2]  <= '0;
      right_r[0]  <= '0;
      right_r[1]  <= '0;
      right_r[2]  <= UNIT;
      up_r[0]     <= '0;
      up_r[1]     <= UNIT;
      up_r[2]     <= '0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            it_r <= in_data;
            unique case (in_data.command)
              CMD_MOVE:   state_r <= S_MV_VEL;
              CMD_TURN:   state_r <= S_TN_YMUL;
              CMD_RELOAD: state_r <= S_RL;
              default:    state_r <= S_DONE;
            endcase
          end
        end

        // ---- move: speed * dt, then each component of each pressed key in turn
        S_MV_VEL: state_r <= S_MV_VLAT;
        S_MV_VLAT: begin
          vel_r   <= vel_sum[40:16];
          k_r     <= '0;
          c_r     <= '0;
          state_r <= S_MV_MUL;
        end
        S_MV_MUL: begin
          if (it_r.key_mask[k_r]) begin
            state_r <= S_MV_ADD;
          end else if (k_r == 2'd3) begin
            state_r <= S_DONE;
          end else begin
            k_r <= k_r + 2'd1;
          end
        end
        S_MV_ADD: begin
          cam_r[c_r] <= sat32(PW'(cam_r[c_r]) + step_d);
          if (c_r == 2'd2) begin
            c_r     <= '0;
            state_r <= (k_r == 2'd3) ? S_DONE : S_MV_MUL;
            k_r     <= k_r + 2'd1;
          end else begin
            c_r     <= c_r + 2'd1;
            state_r <= S_MV_MUL;
          end
        end

        // ---- turn: yaw wrap through the divider, pitch clamp
        S_TN_YMUL: state_r <= S_TN_YDIV;
        S_TN_YDIV: begin
          ysgn_r  <= yaw_sum[PW-1];
          state_r <= S_TN_YWT;
        end
        S_TN_YWT: begin
          if (div_rsp.done) begin
            yaw_r   <= yaw_new[24:0];
            state_r <= S_TN_PMUL;
          end
        end
        S_TN_PMUL: state_r <= S_TN_PADD;
        S_TN_PADD: begin
          if (pitch_sum > PW'(DEG_89))       pitch_r <= 24'(DEG_89);
          else if (pitch_sum < -PW'(DEG_89)) pitch_r <= 24'(-DEG_89);
          else                               pitch_r <= pitch_sum[23:0];
          state_r <= S_RF_CY;
        end

        // ---- reload start pose
        S_RL: begin
          cam_r[0] <= start_x_r;
          cam_r[1] <= start_y_r;
          cam_r[2] <= start_z_r;
          yaw_r    <= start_yaw_r;
          if (ANG_W'(start_pitch_r) > DEG_89)       pitch_r <= 24'(DEG_89);
          else if (ANG_W'(start_pitch_r) < -DEG_89) pitch_r <= 24'(-DEG_89);
          else                                      pitch_r <= start_pitch_r;
          state_r <= S_RF_CY;
        end

        // ---- refresh: sin/cos of yaw and pitch, then front
        S_RF_CY: state_r <= S_RF_CYW;
        S_RF_CYW: begin
          if (cor_rsp.done) begin
            sy_r    <= cor_rsp.sin_v;
            cy_r    <= cor_rsp.cos_v;
            state_r <= S_RF_CP;
          end
        end
        S_RF_CP: state_r <= S_RF_CPW;
        S_RF_CPW: begin
          if (cor_rsp.done) begin
            sp_r    <= cor_rsp.sin_v;
            cp_r    <= cor_rsp.cos_v;
            state_r <= S_RF_F0;
          end
        end
        S_RF_F0: state_r <= S_RF_F2;
        S_RF_F2: begin
          w_r[0]  <= MW'(rnd_sh(prod_r, 30));
          state_r <= S_RF_F2L;
        end
        S_RF_F2L: begin
          w_r[1]  <= sp_r;
          w_r[2]  <= MW'(rnd_sh(prod_r, 30));
          vsel_r  <= VS_FRONT;
          c_r     <= '0;
          sum_r   <= '0;
          state_r <= S_NZ_SQ;
        end

        // ---- normalize w: sum of squares, root, three divides
        S_NZ_SQ: state_r <= S_NZ_ACC;
        S_NZ_ACC: begin
          sum_r <= sum_r + prod_r[63:0];
          if (c_r == 2'd2) begin
            c_r     <= '0;
            state_r <= S_NZ_SQRT;
          end else begin
            c_r     <= c_r + 2'd1;
            state_r <= S_NZ_SQ;
          end
        end
        S_NZ_SQRT: state_r <= S_NZ_SQW;
        S_NZ_SQW: begin
          if (div_rsp.done) begin
            len_r   <= div_rsp.quo;
            state_r <= S_NZ_DIV;
          end
        end
        S_NZ_DIV: begin
          if (len_r == '0) begin
            // degenerate vector comes out all zero
            w_r[c_r] <= '0;
            if (c_r == 2'd2) state_r <= S_NZ_END;
            c_r <= (c_r == 2'd2) ? 2'd0 : c_r + 2'd1;
          end else begin
            state_r <= S_NZ_DIVW;
          end
        end
        S_NZ_DIVW: begin
          if (div_rsp.done) begin
            w_r[c_r] <= w_r[c_r][MW-1] ? -$signed({1'b0, div_rsp.quo})
                                       : $signed({1'b0, div_rsp.quo});
            if (c_r == 2'd2) begin
              c_r     <= '0;
              state_r <= S_NZ_END;
            end else begin
              c_r     <= c_r + 2'd1;
              state_r <= S_NZ_DIV;
            end
          end
        end
        S_NZ_END: begin
          unique case (vsel_r)
            VS_FRONT: begin
              f_r[0]  <= w_r[0];
              f_r[1]  <= w_r[1];
              f_r[2]  <= w_r[2];
              // right = (-front_z, 0, front_x)
              w_r[0]  <= -w_r[2];
              w_r[1]  <= '0;
              w_r[2]  <= w_r[0];
              vsel_r  <= VS_RIGHT;
              sum_r   <= '0;
              state_r <= S_NZ_SQ;
            end
            VS_RIGHT: begin
              r_r[0]  <= w_r[0];
              r_r[1]  <= w_r[1];
              r_r[2]  <= w_r[2];
              state_r <= S_UP_0;
            end
            default: state_r <= S_VEC_OUT;
          endcase
        end

        // ---- up = cross(right, front)
        S_UP_0: state_r <= S_UP_1;
        S_UP_1: begin
          w_r[0]  <= MW'(-rnd_sh(prod_r, 30));
          state_r <= S_UP_2;
        end
        S_UP_2: begin
          acc_r   <= prod_r;
          state_r <= S_UP_3;
        end
        S_UP_3: begin
          w_r[1]  <= MW'(rnd_sh(acc_r - prod_r, 30));
          state_r <= S_UP_4;
        end
        S_UP_4: begin
          w_r[2]  <= MW'(rnd_sh(prod_r, 30));
          vsel_r  <= VS_UP;
          c_r     <= '0;
          sum_r   <= '0;
          state_r <= S_NZ_SQ;
        end

        S_VEC_OUT: begin
          for (int i = 0; i < 3; i++) begin
            front_r[i] <= sat16(rnd_sh(PW'(f_r[i]), VSH));
            right_r[i] <= sat16(rnd_sh(PW'(r_r[i]), VSH));
            up_r[i]    <= sat16(rnd_sh(PW'(w_r[i]), VSH));
          end
          state_r <= S_DONE;
        end

        // Park the result beat once the output register is free
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r        <= 1'b1;
            out_data_r.pos_x   <= cam_r[0];
            out_data_r.pos_y   <= cam_r[1];
            out_data_r.pos_z   <= cam_r[2];
            out_data_r.front_x <= front_r[0];
            out_data_r.front_y <= front_r[1];
            out_data_r.front_z <= front_r[2];
            out_data_r.right_x <= right_r[0];
            out_data_r.right_y <= right_r[1];
            out_data_r.right_z <= right_r[2];
            out_data_r.up_x    <= up_r[0];
            out_data_r.up_y    <= up_r[1];
            out_data_r.up_z    <= up_r[2];
            state_r            <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/fcou_cordic.sv =====
// Iterative 16-step rotation CORDIC giving sine and cosine of an angle in degrees.
module fcou_cordic import fcou_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cor_req_t req,
  output cor_rsp_t rsp
);

  logic                    busy_r;
  logic                    done_r;
  logic [3:0]              step_r;
  logic                    neg_r;
  logic signed [CW-1:0]    x_r;
  logic signed [CW-1:0]    y_r;
  logic signed [ANG_W-1:0] z_r;

  logic signed [ANG_W-1:0] z0;
  logic                    neg0;
  logic signed [CW-1:0]    xs;
  logic signed [CW-1:0]    ys;
  logic signed [ANG_W-1:0] arc;

  always_comb begin
    z0   = ANG_W'(req.ang);
    neg0 = 1'b0;
    if (z0 > DEG_90) begin
      z0   = z0 - DEG_180;
      neg0 = 1'b1;
    end else if (z0 < -DEG_90) begin
      z0   = z0 + DEG_180;
      neg0 = 1'b1;
    end
    xs  = x_r >>> step_r;
    ys  = y_r >>> step_r;
    arc = $signed(ANG_W'(arc_angle(step_r)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        neg_r  <= neg0;
        x_r    <= CORDIC_GAIN;
        y_r    <= '0;
        z_r    <= z0;
      end else if (busy_r) begin
        if (!z_r[ANG_W-1]) begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - arc;
        end else begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + arc;
        end
        step_r <= step_r + 4'd1;
        if (step_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.cos_v = neg_r ? MW'(-x_r) : MW'(x_r);
  assign rsp.sin_v = neg_r ? MW'(-y_r) : MW'(y_r);

endmodule

// ===== hw/rtl/fcou_div.sv =====
// Shared iterative unit: 64/32 restoring divide or 64-bit integer square root, one bit a cycle.
module fcou_div import fcou_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy_r;
  logic        done_r;
  logic        mode_r;
  logic [4:0]  cnt_r;
  logic [63:0] n_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [31:0] rem_r;
  logic [31:0] lo_r;
  logic [31:0] den_r;

  logic [63:0] trial;
  logic [32:0] t;
  logic [32:0] tsub;
  logic        ge;

  always_comb begin
    trial = res_r + bit_r;
    t     = {rem_r, lo_r[31]};
    tsub  = t - {1'b0, den_r};
    ge    = (t >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        mode_r <= req.mode;
        n_r    <= req.num;
        res_r  <= '0;
        bit_r  <= 64'h4000_0000_0000_0000;
        rem_r  <= req.num[63:32];
        lo_r   <= req.num[31:0];
        den_r  <= req.den;
      end else if (busy_r) begin
        if (mode_r == DIV_MODE_SQRT) begin
          if (n_r >= trial) begin
            n_r   <= n_r - trial;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end else begin
          rem_r <= ge ? tsub[31:0] : t[31:0];
          lo_r  <= {lo_r[30:0], ge};
        end
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = (mode_r == DIV_MODE_SQRT) ? res_r[31:0] : lo_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== hw/rtl/fcou_chk.sv =====
// Port-level checker for the fly camera block, with its bind.
module fcou_chk import fcou_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A parked result beat holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // One item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // A new result appears exactly as the block turns idle
  a_rose: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result raised while still busy");

  // Reset leaves the block idle and empty
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind fly_camera_orientation_update fcou_chk u_fcou_chk (.*);
